FILE: hdl/ppg_pkg.sv
// Shared types, constants and width helpers for the PPG DC blocker and
// moving-average block. No dependencies.
package ppg_pkg;

  localparam int OUT_BITS          = 24;
  localparam int COEF_BITS         = 16;
  localparam int ROUND_BITS        = 16;
  localparam int CFG_INDEX_BITS    = 2;

  localparam int DEF_WINDOW_LENGTH = 12;
  localparam int DEF_SAMPLE_BITS   = 18;
  localparam int DEF_FRACTION_BITS = 4;

  localparam logic [COEF_BITS-1:0] COEF_RESET = 16'd62259;

  localparam logic signed [OUT_BITS-1:0] OUT_MAX_V = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OUT_MIN_V = {1'b1, {(OUT_BITS-1){1'b0}}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_HP_COEFFICIENT = 2'd0,
    REG_AVERAGE_ENABLE = 2'd1
  } cfg_reg_t;

  function automatic int sum_width(input int n);
    return OUT_BITS + $clog2(n);
  endfunction

endpackage

FILE: hdl/ppg_win_cell.sv
// One window cell: holds an infrared and a red filtered value and loads
// from its upstream neighbor on shift. Depends on ppg_pkg.
module ppg_win_cell import ppg_pkg::*; (
  input  logic                       clk,
  input  logic                       shift,
  input  logic signed [OUT_BITS-1:0] ir_in,
  input  logic signed [OUT_BITS-1:0] red_in,
  output logic signed [OUT_BITS-1:0] ir_q,
  output logic signed [OUT_BITS-1:0] red_q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      ir_q  <= ir_in;
      red_q <= red_in;
    end
  end

endmodule

FILE: hdl/ppg_dcb.sv
// One-channel DC blocker y = a * (y_prev + (x - x_prev) * 2^FRACTION_BITS)
// with rounding and 24-bit saturation; state advances on load. Depends on ppg_pkg.
module ppg_dcb import ppg_pkg::*; #(
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [COEF_BITS-1:0]       coef,
  input  logic [SAMPLE_BITS-1:0]     x,
  output logic signed [OUT_BITS-1:0] y
);

  localparam int DIFF_W     = SAMPLE_BITS + 1;
  localparam int SCL_W      = DIFF_W + FRACTION_BITS;
  localparam int S_W        = ((SCL_W > OUT_BITS) ? SCL_W : OUT_BITS) + 1;
  localparam int P_W        = S_W + COEF_BITS + 1;
  localparam int Q_W        = P_W - ROUND_BITS;
  localparam int ROUND_HALF = 1 << (ROUND_BITS - 1);

  logic [SAMPLE_BITS-1:0]       last_x;
  logic signed [OUT_BITS-1:0]   last_y;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [S_W-1:0]        s;
  logic signed [COEF_BITS:0]    coef_s;
  logic signed [P_W-1:0]        prod;
  logic signed [P_W-1:0]        bias;
  logic signed [P_W-1:0]        rnd;
  logic signed [Q_W-1:0]        q;
  logic [Q_W-OUT_BITS:0]        hi;

  always_comb begin
    diff   = $signed({1'b0, x}) - $signed({1'b0, last_x});
    s      = S_W'(last_y) + (S_W'(diff) <<< FRACTION_BITS);
    coef_s = $signed({1'b0, coef});
    prod   = s * coef_s;
    bias   = prod[P_W-1] ? P_W'(ROUND_HALF - 1) : P_W'(ROUND_HALF);
    rnd    = prod + bias;
    q      = rnd[P_W-1:ROUND_BITS];
    hi     = q[Q_W-1:OUT_BITS-1];
    if ((&hi) || !(|hi)) begin
      y = q[OUT_BITS-1:0];
    end else begin
      y = q[Q_W-1] ? OUT_MIN_V : OUT_MAX_V;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
    end else if (load) begin
      last_x <= x;
      last_y <= y;
    end
  end

endmodule

FILE: hdl/ppg_mean.sv
// Two-stage rounded division of a window sum by the window length, using a
// reciprocal multiply. Depends on ppg_pkg.
module ppg_mean import ppg_pkg::*; #(
  parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH
) (
  input  logic                                        clk,
  input  logic                                        adv,
  input  logic signed [sum_width(WINDOW_LENGTH)-1:0]  sum,
  output logic signed [OUT_BITS-1:0]                  mean
);

  localparam int LOG_N   = $clog2(WINDOW_LENGTH);
  localparam int SUM_W   = sum_width(WINDOW_LENGTH);
  localparam int MAG_W   = SUM_W;
  localparam int K       = MAG_W + LOG_N;
  localparam int RECIP_W = MAG_W + 1;
  localparam int PR_W    = MAG_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << K) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [MAG_W-1:0]   HALF  = MAG_W'(WINDOW_LENGTH / 2);

  logic [MAG_W-1:0]    abs_sum;
  logic                neg_a;
  logic [MAG_W-1:0]    mag_a;
  logic                neg_b;
  logic [PR_W-1:0]     prod_b;
  logic [OUT_BITS-1:0] q;

  assign abs_sum = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_a  <= sum[SUM_W-1];
      mag_a  <= abs_sum + HALF;
      neg_b  <= neg_a;
      prod_b <= PR_W'(mag_a) * PR_W'(RECIP);
    end
  end

  assign q    = prod_b[K +: OUT_BITS];
  assign mean = neg_b ? -q : q;

endmodule

FILE: hdl/ppg_dc_block_moving_average_top.sv
// Top level of the PPG DC blocker with moving average: configuration
// registers, window cell chain, running sums, pipeline and output skid.
// Depends on ppg_pkg, ppg_dcb, ppg_win_cell and ppg_mean.
//
// One item is accepted per clock cycle while in_stall is low. Both channels
// run a one-pole DC blocker whose recursion closes through last_y and one
// 25 by 17-bit multiplier at the default widths; the window is a chain of
// WINDOW_LENGTH cells that shifts once per averaged item, and a running sum
// per channel feeds a two-stage reciprocal divider. Results are registered
// in valid_a, valid_b and out_valid. In averaging mode the first
// WINDOW_LENGTH items only fill the window and give no result; the fill
// count survives mode changes. A two-entry output stage lets input continue
// while one result waits; in_stall rises only once both entries are held.
// hp_coefficient (index 0) and average_enable (index 1) are written through
// the cfg port, which is always ready; other indexes are ignored.
module ppg_dc_block_moving_average_top import ppg_pkg::*; #(
  parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SAMPLE_BITS-1:0]     ir_sample,
  input  logic [SAMPLE_BITS-1:0]     red_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_BITS-1:0] ir_value,
  output logic signed [OUT_BITS-1:0] red_value,
  output logic                       is_average,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [COEF_BITS-1:0]       cfg_data
);

  localparam int SUM_W  = sum_width(WINDOW_LENGTH);
  localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);

  logic [COEF_BITS-1:0]       hp_coefficient;
  logic                       average_enable;
  logic [FILL_W-1:0]          fill_count;
  logic signed [SUM_W-1:0]    ir_sum;
  logic signed [SUM_W-1:0]    red_sum;
  logic signed [SUM_W-1:0]    ir_sum_next;
  logic signed [SUM_W-1:0]    red_sum_next;

  logic                       accept;
  logic                       adv;
  logic                       full;
  logic                       emits;
  logic                       win_shift;

  logic signed [OUT_BITS-1:0] ir_y;
  logic signed [OUT_BITS-1:0] red_y;
  logic signed [OUT_BITS-1:0] win_ir  [WINDOW_LENGTH+1];
  logic signed [OUT_BITS-1:0] win_red [WINDOW_LENGTH+1];

  logic                       valid_a;
  logic                       avg_a;
  logic signed [OUT_BITS-1:0] ir_a;
  logic signed [OUT_BITS-1:0] red_a;
  logic                       valid_b;
  logic                       avg_b;
  logic signed [OUT_BITS-1:0] ir_b;
  logic signed [OUT_BITS-1:0] red_b;
  logic signed [OUT_BITS-1:0] ir_mean;
  logic signed [OUT_BITS-1:0] red_mean;

  logic                       d_valid;
  logic signed [OUT_BITS-1:0] d_ir;
  logic signed [OUT_BITS-1:0] d_red;

  logic                       skid_full;
  logic signed [OUT_BITS-1:0] skid_ir;
  logic signed [OUT_BITS-1:0] skid_red;
  logic                       skid_avg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hp_coefficient <= COEF_RESET;
      average_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HP_COEFFICIENT: hp_coefficient <= cfg_data;
        REG_AVERAGE_ENABLE: average_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign adv       = ~skid_full;
  assign in_stall  = skid_full;
  assign accept    = in_valid & ~in_stall;
  assign full      = (fill_count == FILL_W'(WINDOW_LENGTH));
  assign emits     = ~average_enable | full;
  assign win_shift = accept & average_enable;

  ppg_dcb #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dcb_ir (
    .clk (clk),
    .rst (rst),
    .load(accept),
    .coef(hp_coefficient),
    .x   (ir_sample),
    .y   (ir_y)
  );

  ppg_dcb #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dcb_red (
    .clk (clk),
    .rst (rst),
    .load(accept),
    .coef(hp_coefficient),
    .x   (red_sample),
    .y   (red_y)
  );

  assign win_ir[WINDOW_LENGTH]  = ir_y;
  assign win_red[WINDOW_LENGTH] = red_y;

  for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
    ppg_win_cell u_cell (
      .clk   (clk),
      .shift (win_shift),
      .ir_in (win_ir[k+1]),
      .red_in(win_red[k+1]),
      .ir_q  (win_ir[k]),
      .red_q (win_red[k])
    );
  end

  always_comb begin
    ir_sum_next  = ir_sum + SUM_W'(ir_y);
    red_sum_next = red_sum + SUM_W'(red_y);
    if (full) begin
      ir_sum_next  = ir_sum_next - SUM_W'(win_ir[0]);
      red_sum_next = red_sum_next - SUM_W'(win_red[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      ir_sum     <= '0;
      red_sum    <= '0;
    end else if (win_shift) begin
      ir_sum  <= ir_sum_next;
      red_sum <= red_sum_next;
      if (!full) begin
        fill_count <= fill_count + FILL_W'(1);
      end
    end
  end

  ppg_mean #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_mean_ir (
    .clk (clk),
    .adv (adv),
    .sum (ir_sum),
    .mean(ir_mean)
  );

  ppg_mean #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_mean_red (
    .clk (clk),
    .adv (adv),
    .sum (red_sum),
    .mean(red_mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else if (adv) begin
      valid_a <= accept & emits;
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      avg_a <= average_enable;
      ir_a  <= ir_y;
      red_a <= red_y;
      avg_b <= avg_a;
      ir_b  <= ir_a;
      red_b <= red_a;
    end
  end

  assign d_valid = valid_b & adv;
  assign d_ir    = avg_b ? ir_mean : ir_b;
  assign d_red   = avg_b ? red_mean : red_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (skid_full) begin
        ir_value   <= skid_ir;
        red_value  <= skid_red;
        is_average <= skid_avg;
        skid_full  <= 1'b0;
      end else if (d_valid) begin
        ir_value   <= d_ir;
        red_value  <= d_red;
        is_average <= avg_b;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (out_valid) begin
      if (d_valid) begin
        skid_ir   <= d_ir;
        skid_red  <= d_red;
        skid_avg  <= avg_b;
        skid_full <= 1'b1;
      end
    end else if (d_valid) begin
      ir_value   <= d_ir;
      red_value  <= d_red;
      is_average <= avg_b;
      out_valid  <= 1'b1;
    end
  end

endmodule

FILE: hdl/ppg_checker.sv
// Port-level checks for the PPG DC blocker top level, and the bind that
// attaches them. Depends on ppg_pkg and ppg_dc_block_moving_average_top.
module ppg_checker import ppg_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [OUT_BITS-1:0] ir_value,
  input logic signed [OUT_BITS-1:0] red_value,
  input logic                       is_average
);

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without a stalled result");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_stall |=> !in_stall)
    else $error("held result not drained after output taken");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ir_value) &&
      $stable(red_value) && $stable(is_average))
    else $error("stalled result changed");

endmodule

bind ppg_dc_block_moving_average_top ppg_checker u_ppg_checker (.*);

FILE: bench/tb_ppg_dc_block_moving_average_top.sv
// Self-checking testbench for ppg_dc_block_moving_average_top: a directed table
// followed by randomized setting phases, checked against an in-bench predictor.
// Depends on ppg_pkg and the RTL under hdl/.
module tb_ppg_dc_block_moving_average_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ppg_pkg::*;

  localparam int SB = DEF_SAMPLE_BITS;
  localparam int WL = DEF_WINDOW_LENGTH;
  localparam int FB = DEF_FRACTION_BITS;
  localparam int RANDOM_SAMPLES = 1300;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [SB-1:0] SMAX = {SB{1'b1}};
  localparam logic [SB-1:0] PAT_A = 18'h2AAAA;
  localparam logic [SB-1:0] PAT_B = 18'h15555;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] ir;
    logic signed [OUT_BITS-1:0] red;
    logic                       avg;
  } result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [COEF_BITS-1:0]      data;
    logic [SB-1:0]             ir;
    logic [SB-1:0]             red;
    logic [4:0]                repeats;
    logic                      typed;
    result_t                   want;
  } plan_row_t;

  localparam result_t NO_RESULT = '0;
  localparam result_t BYPASS_ZERO = '{24'sd0, 24'sd0, 1'b0};
  localparam result_t MEAN_ZERO = '{24'sd0, 24'sd0, 1'b1};
  localparam int PLAN_ROWS = 28;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, 18'h0, 18'h0, 5'd1, 1'b1, BYPASS_ZERO},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, SMAX, SMAX, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, 18'h0, SMAX, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, SMAX, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_HP_COEFFICIENT, 16'h0000, 18'h0, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, SMAX, 18'h0, 5'd1, 1'b1, BYPASS_ZERO},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, PAT_A, PAT_B, 5'd1, 1'b1, BYPASS_ZERO},
    '{ROW_WRITE, REG_HP_COEFFICIENT, 16'hFFFF, 18'h0, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, 18'h0, SMAX, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, SMAX, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, SMAX, SMAX, 5'd1, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_HP_COEFFICIENT, 16'h0001, 18'h0, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, 18'h0, SMAX, 5'd1, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_SPARE_2, 16'hFFFF, 18'h0, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_SPARE_3, 16'h0000, 18'h0, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, SMAX, SMAX, 5'd1, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_HP_COEFFICIENT, 16'h0000, 18'h0, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_AVERAGE_ENABLE, 16'hFFFF, 18'h0, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, SMAX, 18'h0, 5'd5, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_AVERAGE_ENABLE, 16'hFFFE, 18'h0, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, 18'h0, SMAX, 5'd1, 1'b1, BYPASS_ZERO},
    '{ROW_WRITE, REG_AVERAGE_ENABLE, 16'h0001, 18'h0, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, SMAX, 18'h0, 5'd7, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, PAT_B, PAT_A, 5'd1, 1'b1, MEAN_ZERO},
    '{ROW_WRITE, REG_AVERAGE_ENABLE, 16'h0000, 18'h0, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, 18'h0, 18'h0, 5'd1, 1'b1, BYPASS_ZERO},
    '{ROW_WRITE, REG_HP_COEFFICIENT, COEF_RESET, 18'h0, 18'h0, 5'd1, 1'b0, NO_RESULT},
    '{ROW_SAMPLE, REG_HP_COEFFICIENT, 16'h0000, 18'h1, 18'h1, 5'd1, 1'b0, NO_RESULT}
  };

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [SB-1:0]              ir_sample;
  logic [SB-1:0]              red_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [OUT_BITS-1:0] ir_value;
  logic signed [OUT_BITS-1:0] red_value;
  logic                       is_average;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  logic [COEF_BITS-1:0]       cfg_data;

  logic [COEF_BITS-1:0]       pole_coef;
  logic                       mean_mode;
  logic [SB-1:0]              prev_raw [2];
  logic signed [OUT_BITS-1:0] prev_filt [2];
  logic signed [OUT_BITS-1:0] window [2][WL];
  int                         fill_level;

  result_t pending_results [$];
  result_t head;
  int mismatches;
  int samples_sent;
  int results_checked;
  int means_checked;
  int phases_run;
  int burst_left;

  ppg_dc_block_moving_average_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ir_sample  (ir_sample),
    .red_sample (red_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ir_value   (ir_value),
    .red_value  (red_value),
    .is_average (is_average),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] dc_filter(input int ch, input logic [SB-1:0] x);
    longint acc;
    longint y;
    acc = longint'(prev_filt[ch])
        + (longint'({1'b0, x}) - longint'({1'b0, prev_raw[ch]})) * (longint'(1) << FB);
    y = round_div(acc * longint'({1'b0, pole_coef}), 65536);
    if (y > longint'(OUT_MAX_V)) y = longint'(OUT_MAX_V);
    if (y < longint'(OUT_MIN_V)) y = longint'(OUT_MIN_V);
    prev_raw[ch] = x;
    prev_filt[ch] = OUT_BITS'(y);
    return OUT_BITS'(y);
  endfunction

  function automatic bit predict_item(input logic [SB-1:0] ir, input logic [SB-1:0] red,
                                      output result_t r);
    logic signed [OUT_BITS-1:0] filt [2];
    longint sum [2];
    filt[0] = dc_filter(0, ir);
    filt[1] = dc_filter(1, red);
    r = '0;
    if (!mean_mode) begin
      r.ir = filt[0];
      r.red = filt[1];
      return 1'b1;
    end
    if (fill_level < WL) begin
      window[0][fill_level] = filt[0];
      window[1][fill_level] = filt[1];
      fill_level++;
      return 1'b0;
    end
    for (int ch = 0; ch < 2; ch++) begin
      sum[ch] = 0;
      for (int k = 0; k < WL; k++) sum[ch] += longint'(window[ch][k]);
      for (int k = 0; k < WL - 1; k++) window[ch][k] = window[ch][k + 1];
      window[ch][WL - 1] = filt[ch];
    end
    r.ir = OUT_BITS'(round_div(sum[0], WL));
    r.red = OUT_BITS'(round_div(sum[1], WL));
    r.avg = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [SB-1:0] draw_sample(input int style, input logic [SB-1:0] level);
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 9) < 3) return r[SB-1:0];
    case (style)
      0: return r[SB-1:0];
      1: return level ^ {{(SB-8){1'b0}}, r[7:0]};
      2: return r[0] ? SMAX : '0;
      default: return level;
    endcase
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [COEF_BITS-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_HP_COEFFICIENT: pole_coef = data;
      REG_AVERAGE_ENABLE: mean_mode = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [SB-1:0] ir, input logic [SB-1:0] red,
                             input bit typed, input result_t want);
    int gap;
    bit has;
    result_t got;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    ir_sample <= ir;
    red_sample <= red;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = predict_item(ir, red, got);
    if (typed) pending_results.push_back(want);
    else if (has) pending_results.push_back(got);
    samples_sent++;
    @(negedge clk);
  endtask

  initial begin
    int hold;
    int len;
    int pick;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        hold = 0;
        len = $urandom_range(1, 8);
      end else if (pick < 7) begin
        hold = 1;
        len = $urandom_range(1, 3);
      end else if (pick < 8) begin
        hold = 1;
        len = $urandom_range(8, 24);
      end else begin
        hold = 0;
        len = $urandom_range(20, 80);
      end
      out_stall <= hold[0];
      repeat (len) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ir %0d red %0d avg %0b", ir_value, red_value, is_average);
      end else begin
        head = pending_results.pop_front();
        results_checked++;
        if (head.avg) means_checked++;
        if (ir_value !== head.ir || red_value !== head.red || is_average !== head.avg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: ir %0d/%0d red %0d/%0d avg %0b/%0b (expected/actual)",
                     results_checked, $signed(head.ir), ir_value, $signed(head.red), red_value,
                     head.avg, is_average);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still pending", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int random_sent;
    int count;
    int style;
    logic [31:0] r;
    logic [SB-1:0] ir_level;
    logic [SB-1:0] red_level;
    rst = 1'b1;
    in_valid = 1'b0;
    ir_sample = '0;
    red_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_HP_COEFFICIENT;
    cfg_data = '0;
    pole_coef = COEF_RESET;
    mean_mode = 1'b0;
    prev_raw = '{default: '0};
    prev_filt = '{default: '0};
    window = '{default: '{default: '0}};
    fill_level = 0;
    mismatches = 0;
    samples_sent = 0;
    results_checked = 0;
    means_checked = 0;
    phases_run = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        write_reg(PLAN[i].index, PLAN[i].data);
      end else begin
        for (int n = 0; n < PLAN[i].repeats; n++)
          send_sample(PLAN[i].ir, PLAN[i].red, PLAN[i].typed, PLAN[i].want);
      end
    end

    random_sent = 0;
    while (random_sent < RANDOM_SAMPLES) begin
      r = $urandom;
      case ($urandom_range(0, 5))
        0: write_reg(REG_HP_COEFFICIENT, '0);
        1: write_reg(REG_HP_COEFFICIENT, '1);
        2: write_reg(REG_HP_COEFFICIENT, COEF_RESET);
        3: write_reg(REG_HP_COEFFICIENT, r[15:0]);
        default: write_reg(REG_HP_COEFFICIENT, COEF_BITS'($urandom_range(55000, 65535)));
      endcase
      r = $urandom;
      write_reg(REG_AVERAGE_ENABLE, {r[15:1], ($urandom_range(0, 2) != 0)});
      if ($urandom_range(0, 5) == 0) begin
        r = $urandom;
        write_reg(r[16] ? REG_SPARE_2 : REG_SPARE_3, r[15:0]);
      end
      style = $urandom_range(0, 3);
      r = $urandom;
      ir_level = r[SB-1:0];
      r = $urandom;
      red_level = r[SB-1:0];
      count = $urandom_range(16, 80);
      for (int n = 0; n < count; n++)
        send_sample(draw_sample(style, ir_level), draw_sample(style, red_level), 1'b0, NO_RESULT);
      random_sent += count;
      phases_run++;
    end

    wait_idle();
    $display("ran %0d samples over %0d random setting phases after the directed table",
             samples_sent, phases_run);
    $display("checked %0d results, %0d of them window means, %0d mismatches",
             results_checked, means_checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
